### hdl/vna_pkg.sv
package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int FRAC_BITS    = 12;

   localparam int ADDR_W     = $clog2(MAX_VERTICES);
   localparam int IDX_W      = 11;
   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int NRM_W      = CROSS_W - FRAC_BITS;
   localparam int ACC_W      = 48;
   localparam int SMAG_W     = 24;
   localparam int LEN2_W     = 2 * SMAG_W + 2;
   localparam int ROOT_W     = LEN2_W + 1;
   localparam int UNIT_SHIFT = 14;
   localparam int QUO_W      = UNIT_SHIFT + 1;
   localparam int REM_W      = SMAG_W + UNIT_SHIFT + 2;
   localparam int CNT_W      = $clog2(UNIT_SHIFT + 1);
   localparam int NORM_W     = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int VTX_W      = 3 * COORD_W;
   localparam int ACCV_W     = 3 * ACC_W;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_FACE   = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   localparam logic [2:0] CORNERS_TRI  = 3'd3;
   localparam logic [2:0] CORNERS_QUAD = 3'd4;

   typedef enum logic [2:0] {
      OP_PASS,
      OP_VERTEX,
      OP_TRI,
      OP_QUAD,
      OP_QUERY
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_VRD,
      S_MUL,
      S_ARD,
      S_AWR,
      S_QRD,
      S_QCAP,
      S_SHIFT,
      S_SQ,
      S_SQRT,
      S_DIVINIT,
      S_DIV,
      S_DONE
   } bstate_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic [IDX_W-1:0]          index_a;
      logic [IDX_W-1:0]          index_b;
      logic [IDX_W-1:0]          index_c;
      logic [IDX_W-1:0]          index_d;
      logic [2:0]                corner_count;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      logic [1:0]                status;
      logic [ADDR_W-1:0]         addr_a;
      logic [ADDR_W-1:0]         addr_b;
      logic [ADDR_W-1:0]         addr_c;
      logic [ADDR_W-1:0]         addr_d;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### hdl/vna_ram.sv
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/vna_front.sv
module vna_front import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    fifo_full,
   output logic    push,
   output cmd_type push_data
);

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic             ok_a;
   logic             ok_b;
   logic             ok_c;
   logic             ok_d;
   logic             shape_ok;
   logic             is_quad;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] z;
      z = i - IDX_W'(1);
      return z[ADDR_W-1:0];
   endfunction

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   assign ok_a     = (req_data.index_a != '0) && (req_data.index_a <= count_ff);
   assign ok_b     = (req_data.index_b != '0) && (req_data.index_b <= count_ff);
   assign ok_c     = (req_data.index_c != '0) && (req_data.index_c <= count_ff);
   assign ok_d     = (req_data.index_d != '0) && (req_data.index_d <= count_ff);
   assign is_quad  = (req_data.corner_count == CORNERS_QUAD);
   assign shape_ok = (req_data.corner_count == CORNERS_TRI) || is_quad;

   always_comb begin
      count_in         = count_ff;
      push_data.op     = OP_PASS;
      push_data.status = ST_OK;
      push_data.addr_a = to_addr(req_data.index_a);
      push_data.addr_b = to_addr(req_data.index_b);
      push_data.addr_c = to_addr(req_data.index_c);
      push_data.addr_d = to_addr(req_data.index_d);
      push_data.pos_x  = req_data.pos_x;
      push_data.pos_y  = req_data.pos_y;
      push_data.pos_z  = req_data.pos_z;
      case (req_data.kind)
         KIND_CLEAR: begin
            count_in = '0;
         end
         KIND_VERTEX: begin
            if (req_data.index_a == '0 || req_data.index_a > IDX_W'(MAX_VERTICES)) begin
               push_data.status = ST_RANGE;
            end else begin
               push_data.op = OP_VERTEX;
               if (req_data.index_a > count_ff) begin
                  count_in = req_data.index_a;
               end
            end
         end
         KIND_FACE: begin
            if (!shape_ok || !ok_a || !ok_b || !ok_c || (is_quad && !ok_d)) begin
               push_data.status = ST_RANGE;
            end else begin
               push_data.op = is_quad ? OP_QUAD : OP_TRI;
            end
         end
         default: begin
            if (!ok_a) begin
               push_data.status = ST_RANGE;
            end else begin
               push_data.op = OP_QUERY;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_in;
      end
   end

endmodule

### hdl/vna_fifo.sv
module vna_fifo import vna_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_data,
   input  logic          pop,
   output cmd_type       head,
   output fifo_stat_type stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue count out of range");

endmodule

### hdl/vna_back.sv
module vna_back import vna_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       head,
   input  fifo_stat_type fstat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   bstate_type               state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     pass_ff, pass_in;
   logic [2:0]               step_ff, step_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [COORD_W-1:0] o_ff [3];
   logic signed [COORD_W-1:0] o_in [3];
   logic signed [DIFF_W-1:0] da_ff [3];
   logic signed [DIFF_W-1:0] da_in [3];
   logic signed [DIFF_W-1:0] db_ff [3];
   logic signed [DIFF_W-1:0] db_in [3];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] first_ff, first_in;
   logic signed [NRM_W-1:0]  nrm_ff [3];
   logic signed [NRM_W-1:0]  nrm_in [3];
   logic [ACC_W-1:0]         mag_ff [3];
   logic [ACC_W-1:0]         mag_in [3];
   logic [2:0]               neg_ff, neg_in;
   logic [LEN2_W-1:0]        len2_ff, len2_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [ROOT_W-1:0]        rad_ff, rad_in;
   logic [ROOT_W-1:0]        bit_ff, bit_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         dsh_ff, dsh_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic signed [NORM_W-1:0] out_ff [3];
   logic signed [NORM_W-1:0] out_in [3];
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic [ADDR_W-1:0]        vtx_rd_addr;
   logic [VTX_W-1:0]         vtx_rd_data;
   logic                     vtx_wr_en;
   logic [ADDR_W-1:0]        acc_rd_addr;
   logic [ACCV_W-1:0]        acc_rd_data;
   logic                     acc_wr_en;
   logic [ADDR_W-1:0]        acc_wr_addr;
   logic [ACCV_W-1:0]        acc_wr_data;
   logic [ADDR_W-1:0]        corner_addr;
   logic signed [CROSS_W-1:0] crs;
   logic                     slot_free;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic signed [NRM_W-1:0] n);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {{(ACC_W + 1 - NRM_W){n[NRM_W-1]}}, n};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   vna_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_wr_en),
      .wr_addr (head.addr_a),
      .wr_data ({head.pos_x, head.pos_y, head.pos_z}),
      .rd_addr (vtx_rd_addr),
      .rd_data (vtx_rd_data)
   );

   vna_ram #(.WIDTH(ACCV_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign prod_in   = mul_a * mul_b;
   assign crs       = CROSS_W'(first_ff) - CROSS_W'(prod_ff);

   // corner walk: first pass a, b, c; second pass a, c, d
   always_comb begin
      case (step_ff)
         3'd0:    corner_addr = cmd_ff.addr_a;
         3'd1:    corner_addr = pass_ff ? cmd_ff.addr_c : cmd_ff.addr_b;
         default: corner_addr = pass_ff ? cmd_ff.addr_d : cmd_ff.addr_c;
      endcase
   end

   always_comb begin
      case (step_ff)
         3'd0:    vtx_rd_addr = pass_ff ? cmd_ff.addr_c : cmd_ff.addr_b;
         3'd1:    vtx_rd_addr = cmd_ff.addr_a;
         default: vtx_rd_addr = pass_ff ? cmd_ff.addr_d : cmd_ff.addr_c;
      endcase
   end

   // one shared multiplier: cross terms, then squares of magnitudes
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_MUL) begin
         case (step_ff)
            3'd0: begin mul_a = da_ff[1]; mul_b = db_ff[2]; end
            3'd1: begin mul_a = da_ff[2]; mul_b = db_ff[1]; end
            3'd2: begin mul_a = da_ff[2]; mul_b = db_ff[0]; end
            3'd3: begin mul_a = da_ff[0]; mul_b = db_ff[2]; end
            3'd4: begin mul_a = da_ff[0]; mul_b = db_ff[1]; end
            3'd5: begin mul_a = da_ff[1]; mul_b = db_ff[0]; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == S_SQ) begin
         case (step_ff)
            3'd0: mul_a = {1'b0, mag_ff[0][SMAG_W-1:0]};
            3'd1: mul_a = {1'b0, mag_ff[1][SMAG_W-1:0]};
            3'd2: mul_a = {1'b0, mag_ff[2][SMAG_W-1:0]};
            default: mul_a = '0;
         endcase
         mul_b = mul_a;
      end
   end

   always_comb begin
      logic [ROOT_W-1:0] trial;
      logic [REM_W-1:0]  num;
      logic              ge;
      logic              any_big;
      logic              all_zero;
      logic [ACC_W-1:0]  comp;
      logic signed [NORM_W-1:0] qs;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pass_in      = pass_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      len2_in      = len2_ff;
      root_in      = root_ff;
      rad_in       = rad_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      for (int k = 0; k < 3; k++) begin
         o_in[k]   = o_ff[k];
         da_in[k]  = da_ff[k];
         db_in[k]  = db_ff[k];
         nrm_in[k] = nrm_ff[k];
         mag_in[k] = mag_ff[k];
         out_in[k] = out_ff[k];
      end
      pop         = 1'b0;
      vtx_wr_en   = 1'b0;
      acc_wr_en   = 1'b0;
      acc_wr_addr = corner_addr;
      acc_wr_data = '0;
      acc_rd_addr = corner_addr;
      trial       = root_ff + bit_ff;
      num         = '0;
      ge          = 1'b0;
      any_big     = 1'b0;
      all_zero    = 1'b1;
      comp        = '0;
      qs          = '0;

      case (state_ff)
         S_IDLE: begin
            if (!fstat.empty) begin
               pop       = 1'b1;
               cmd_in    = head;
               pass_in   = 1'b0;
               step_in   = '0;
               status_in = head.status;
               for (int k = 0; k < 3; k++) begin
                  out_in[k] = '0;
               end
               case (head.op)
                  OP_VERTEX: begin
                     vtx_wr_en   = 1'b1;
                     acc_wr_en   = 1'b1;
                     acc_wr_addr = head.addr_a;
                     acc_wr_data = '0;
                     state_in    = S_DONE;
                  end
                  OP_TRI, OP_QUAD: state_in = S_VRD;
                  OP_QUERY:        state_in = S_QRD;
                  default:         state_in = S_DONE;
               endcase
            end
         end
         S_VRD: begin
            // read o, then p, then q; form p - o and q - o as they land
            for (int k = 0; k < 3; k++) begin
               if (step_ff == 3'd1) begin
                  o_in[k] = vtx_rd_data[(2 - k) * COORD_W +: COORD_W];
               end else if (step_ff == 3'd2) begin
                  da_in[k] = DIFF_W'($signed(vtx_rd_data[(2 - k) * COORD_W +: COORD_W]))
                             - DIFF_W'(o_ff[k]);
               end else if (step_ff == 3'd3) begin
                  db_in[k] = DIFF_W'($signed(vtx_rd_data[(2 - k) * COORD_W +: COORD_W]))
                             - DIFF_W'(o_ff[k]);
               end
            end
            if (step_ff == 3'd3) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MUL: begin
            if (step_ff != 3'd0) begin
               if (!step_ff[0]) begin
                  nrm_in[step_ff[2:1] - 2'd1] = crs[CROSS_W-1:FRAC_BITS];
               end else begin
                  first_in = prod_ff;
               end
            end
            if (step_ff == 3'd6) begin
               step_in  = '0;
               state_in = S_ARD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ARD: begin
            state_in = S_AWR;
         end
         S_AWR: begin
            acc_wr_en = 1'b1;
            for (int k = 0; k < 3; k++) begin
               acc_wr_data[(2 - k) * ACC_W +: ACC_W] =
                  sat_add(acc_rd_data[(2 - k) * ACC_W +: ACC_W], nrm_ff[k]);
            end
            if (step_ff == 3'd2) begin
               step_in = '0;
               if (cmd_ff.op == OP_QUAD && !pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_VRD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_QRD: begin
            acc_rd_addr = cmd_ff.addr_a;
            state_in    = S_QCAP;
         end
         S_QCAP: begin
            for (int k = 0; k < 3; k++) begin
               comp      = acc_rd_data[(2 - k) * ACC_W +: ACC_W];
               neg_in[k] = comp[ACC_W-1];
               mag_in[k] = comp[ACC_W-1] ? ('0 - comp) : comp;
               if (comp != '0) begin
                  all_zero = 1'b0;
               end
            end
            if (all_zero) begin
               status_in = ST_ZERO;
               state_in  = S_DONE;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            for (int k = 0; k < 3; k++) begin
               if (mag_ff[k][ACC_W-1:SMAG_W] != '0) begin
                  any_big = 1'b1;
               end
            end
            if (any_big) begin
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = mag_ff[k] >> 1;
               end
            end else begin
               len2_in  = '0;
               step_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (step_ff != 3'd0) begin
               len2_in = len2_ff + LEN2_W'(prod_ff[2*SMAG_W-1:0]);
            end
            if (step_ff == 3'd3) begin
               rad_in   = ROOT_W'(len2_in);
               root_in  = '0;
               bit_in   = ROOT_W'(1) << (2 * SMAG_W);
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SQRT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               step_in  = '0;
               state_in = S_DIVINIT;
            end
         end
         S_DIVINIT: begin
            case (step_ff)
               3'd0:    comp = mag_ff[0];
               3'd1:    comp = mag_ff[1];
               default: comp = mag_ff[2];
            endcase
            num      = REM_W'({comp[SMAG_W-1:0], {UNIT_SHIFT{1'b0}}})
                       + REM_W'(root_ff[SMAG_W:1]);
            rem_in   = num;
            dsh_in   = REM_W'({root_ff[SMAG_W:0], {UNIT_SHIFT{1'b0}}});
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            ge = (rem_ff >= dsh_ff);
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[QUO_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(UNIT_SHIFT)) begin
               qs = NORM_W'(quo_in);
               for (int k = 0; k < 3; k++) begin
                  if (step_ff == 3'(k)) begin
                     out_in[k] = neg_ff[k] ? -qs : qs;
                  end
               end
               if (step_ff == 3'd2) begin
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = S_DIVINIT;
               end
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.normal_x = out_ff[0];
               rsp_data_in.normal_y = out_ff[1];
               rsp_data_in.normal_z = out_ff[2];
               rsp_data_in.status   = status_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pass_ff     <= pass_in;
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      first_ff    <= first_in;
      neg_ff      <= neg_in;
      len2_ff     <= len2_in;
      root_ff     <= root_in;
      rad_ff      <= rad_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < 3; k++) begin
         o_ff[k]   <= o_in[k];
         da_ff[k]  <= da_in[k];
         db_ff[k]  <= db_in[k];
         nrm_ff[k] <= nrm_in[k];
         mag_ff[k] <= mag_in[k];
         out_ff[k] <= out_in[k];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE)
      else $error("queue popped while busy");

   a_acc_write_src: assert property (@(posedge clock) disable iff (reset)
      acc_wr_en |-> (state_ff == S_IDLE || state_ff == S_AWR))
      else $error("accumulator written outside vertex load or update");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVINIT |-> root_ff != '0)
      else $error("zero length reached the divider");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) |-> state_ff == S_DONE)
      else $error("result loaded outside done state");

endmodule

### hdl/vertex_normal_accumulator_top.sv
// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_stall  req_type: kind, indices, corners, position
// rsp_      out        rsp_valid/rsp_stall  rsp_type: normal_x/y/z (Q1.14), status
//
// Clear, rejected items and vertex writes go straight to the result; a quad runs the
// triangle sequence twice; a query with a zero sum ends early, else it runs the
// normalizer shift, the bit-pair square root and three divides, one per component.
// The shared multiplier and the one read port on each RAM set the pace of face updates.
// Reset is synchronous; it clears vertex count, queue and sequencer, not the RAMs.
// A stalled result holds in the output register while the front keeps filling the queue.
module vertex_normal_accumulator_top import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic          push;
   cmd_type       push_data;
   logic          pop;
   cmd_type       head;
   fifo_stat_type fstat;

   // front: check indices against the live vertex count, classify the beat
   vna_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (fstat.full),
      .push      (push),
      .push_data (push_data)
   );

   // decouple: hold classified commands while the back end iterates
   vna_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (fstat)
   );

   // back: vertex and accumulator RAMs, cross products, normalize
   vna_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .fstat     (fstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb_vertex_normal_accumulator_top.sv
`timescale 1ns / 1ps
module tb_vertex_normal_accumulator_top;
   import vna_pkg::*;

   localparam longint ACC_HI = (64'sd1 <<< 47) - 64'sd1;
   localparam longint ACC_LO = -(64'sd1 <<< 47);
   localparam int IDLE_LIMIT = 20000;   // cycles with no beat on either channel
   localparam int DRAIN_CYCLES = 200;   // extra wait after the last expected result
   localparam int HAMMER_QUADS = 200;   // quads of both windings stacked on one square
   localparam int RANDOM_ITEMS = 900;
   localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   vertex_normal_accumulator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: positions, per-vertex normal sums and the live vertex count.
   longint      pos_mem [3][MAX_VERTICES];
   longint      sum_mem [3][MAX_VERTICES];
   int unsigned vtx_total = 0;

   // Generator view: which entries were ever written, and the count it expects.
   bit          ever_written [MAX_VERTICES+1];
   int          live_list [$];
   int unsigned gen_total = 0;

   req_type     pending [$];
   rsp_type     normals_due [$];

   int errors = 0;
   int idle_cycles = 0;
   int beats_in = 0;
   int ok_queries = 0;
   int zero_queries = 0;
   int rejects = 0;
   int saturated_seen = 0;
   bit req_taken = 1'b0;

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------
   function automatic bit in_range(int unsigned idx);
      return idx >= 1 && idx <= vtx_total;
   endfunction

   // (p - o) x (q - o), each component floored by FRAC_BITS
   function automatic void face_cross(int p, int o, int q, output longint n[3]);
      longint u[3], w[3];
      for (int k = 0; k < 3; k++) begin
         u[k] = pos_mem[k][p] - pos_mem[k][o];
         w[k] = pos_mem[k][q] - pos_mem[k][o];
      end
      n[0] = (u[1] * w[2] - u[2] * w[1]) >>> FRAC_BITS;
      n[1] = (u[2] * w[0] - u[0] * w[2]) >>> FRAC_BITS;
      n[2] = (u[0] * w[1] - u[1] * w[0]) >>> FRAC_BITS;
   endfunction

   function automatic void add_clamped(int v, longint n[3]);
      longint s;
      for (int k = 0; k < 3; k++) begin
         s = sum_mem[k][v] + n[k];
         if (s > ACC_HI) s = ACC_HI;
         if (s < ACC_LO) s = ACC_LO;
         sum_mem[k][v] = s;
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type unit_normal(int v);
      rsp_type         res;
      longint unsigned mag[3], peak, len2, len, q;
      int              sh;
      logic [NORM_W-1:0] comp[3];
      res = '0;
      peak = 0;
      len2 = 0;
      sh = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (sum_mem[k][v] < 0) ? longint'(-sum_mem[k][v]) : longint'(sum_mem[k][v]);
         if (mag[k] > peak) peak = mag[k];
         if (sum_mem[k][v] == ACC_HI || sum_mem[k][v] == ACC_LO) saturated_seen++;
      end
      if (peak == 0) begin
         res.status = ST_ZERO;
         return res;
      end
      while ((peak >> sh) >= (64'd1 << SMAG_W)) sh++;
      for (int k = 0; k < 3; k++) begin
         mag[k] = mag[k] >> sh;
         len2 += mag[k] * mag[k];
      end
      len = int_sqrt(len2);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 64'd16384 + len / 2) / len;
         comp[k] = (sum_mem[k][v] < 0) ? NORM_W'(-q) : NORM_W'(q);
      end
      res.normal_x = comp[0];
      res.normal_y = comp[1];
      res.normal_z = comp[2];
      res.status = ST_OK;
      return res;
   endfunction

   function automatic rsp_type predict_normal(req_type r);
      rsp_type res;
      longint  t0[3], t1[3];
      int      a, b, c, d;
      res = '0;
      res.status = ST_OK;
      a = int'(r.index_a) - 1;
      b = int'(r.index_b) - 1;
      c = int'(r.index_c) - 1;
      d = int'(r.index_d) - 1;
      case (r.kind)
         KIND_CLEAR: begin
            vtx_total = 0;
         end
         KIND_VERTEX: begin
            if (r.index_a < 1 || r.index_a > MAX_VERTICES) begin
               res.status = ST_RANGE;
            end else begin
               pos_mem[0][a] = longint'(r.pos_x);
               pos_mem[1][a] = longint'(r.pos_y);
               pos_mem[2][a] = longint'(r.pos_z);
               for (int k = 0; k < 3; k++) sum_mem[k][a] = 0;
               if (r.index_a > vtx_total) vtx_total = r.index_a;
            end
         end
         KIND_FACE: begin
            if ((r.corner_count != CORNERS_TRI && r.corner_count != CORNERS_QUAD) ||
                !in_range(r.index_a) || !in_range(r.index_b) || !in_range(r.index_c) ||
                (r.corner_count == CORNERS_QUAD && !in_range(r.index_d))) begin
               res.status = ST_RANGE;
            end else begin
               face_cross(a, b, c, t0);
               add_clamped(a, t0);
               add_clamped(b, t0);
               add_clamped(c, t0);
               if (r.corner_count == CORNERS_QUAD) begin
                  face_cross(a, c, d, t1);
                  add_clamped(a, t1);
                  add_clamped(c, t1);
                  add_clamped(d, t1);
               end
            end
         end
         default: begin
            if (!in_range(r.index_a)) res.status = ST_RANGE;
            else res = unit_normal(a);
         end
      endcase
      if (res.status == ST_OK && r.kind == KIND_QUERY) ok_queries++;
      if (res.status == ST_ZERO) zero_queries++;
      if (res.status == ST_RANGE) rejects++;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   function automatic req_type make_item(logic [1:0] kind, int ia, int ib, int ic, int id,
                                         int cc, logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] z);
      req_type r;
      r.kind = kind;
      r.index_a = IDX_W'(ia);
      r.index_b = IDX_W'(ib);
      r.index_c = IDX_W'(ic);
      r.index_d = IDX_W'(id);
      r.corner_count = 3'(cc);
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      return r;
   endfunction

   function automatic bit reads_unwritten(req_type r);
      bit face_live;
      if (r.kind == KIND_QUERY)
         return r.index_a >= 1 && r.index_a <= gen_total && !ever_written[r.index_a];
      if (r.kind != KIND_FACE) return 1'b0;
      if (r.corner_count != CORNERS_TRI && r.corner_count != CORNERS_QUAD) return 1'b0;
      face_live = r.index_a >= 1 && r.index_a <= gen_total &&
                  r.index_b >= 1 && r.index_b <= gen_total &&
                  r.index_c >= 1 && r.index_c <= gen_total &&
                  (r.corner_count == CORNERS_TRI ||
                   (r.index_d >= 1 && r.index_d <= gen_total));
      if (!face_live) return 1'b0;
      return !ever_written[r.index_a] || !ever_written[r.index_b] ||
             !ever_written[r.index_c] ||
             (r.corner_count == CORNERS_QUAD && !ever_written[r.index_d]);
   endfunction

   // Queue one beat and advance the generator's view of the vertex table.
   function automatic void queue_item(req_type r);
      if (reads_unwritten(r)) r.index_a = '0;
      pending = {pending, r};
      if (r.kind == KIND_CLEAR) begin
         gen_total = 0;
      end else if (r.kind == KIND_VERTEX && r.index_a >= 1 && r.index_a <= MAX_VERTICES) begin
         if (!ever_written[r.index_a]) live_list = {live_list, int'(r.index_a)};
         ever_written[r.index_a] = 1'b1;
         if (r.index_a > gen_total) gen_total = r.index_a;
      end
   endfunction

   function automatic int pick_live();
      int cand [$];
      foreach (live_list[i]) if (live_list[i] <= int'(gen_total)) cand = {cand, live_list[i]};
      if (cand.size() == 0) return 0;
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   function automatic int pick_bad();
      if ($urandom_range(1)) return 0;
      return $urandom_range(2047, gen_total + 1);
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3: return COORD_W'(raw[11:0]) - COORD_W'(2048);
         default: return raw[COORD_W-1:0];
      endcase
   endfunction

   function automatic req_type random_item();
      req_type     r;
      logic [127:0] raw;
      int          sel;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      sel = $urandom_range(99);
      if (sel < 4) begin
         r.kind = KIND_CLEAR;
      end else if (sel < 34) begin
         r.kind = KIND_VERTEX;
         r.pos_x = rand_coord();
         r.pos_y = rand_coord();
         r.pos_z = rand_coord();
         case ($urandom_range(19))
            0:       r.index_a = IDX_W'(pick_bad());
            1, 2:    r.index_a = IDX_W'($urandom_range(MAX_VERTICES, 1));
            default: r.index_a = IDX_W'($urandom_range(24, 1));
         endcase
      end else if (sel < 69) begin
         r.kind = KIND_FACE;
         r.corner_count = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) :
                          ($urandom_range(1) ? CORNERS_QUAD : CORNERS_TRI);
         r.index_a = IDX_W'(pick_live());
         r.index_b = IDX_W'(pick_live());
         r.index_c = IDX_W'(pick_live());
         r.index_d = IDX_W'(pick_live());
         case ($urandom_range(39))
            0: r.index_a = IDX_W'(pick_bad());
            1: r.index_b = IDX_W'(pick_bad());
            2: r.index_c = IDX_W'(pick_bad());
            3: r.index_d = IDX_W'(pick_bad());
            default: ;
         endcase
      end else if (sel < 94) begin
         r.kind = KIND_QUERY;
         r.index_a = IDX_W'(($urandom_range(9) == 0) ? pick_bad() : pick_live());
      end
      // the rest stays raw noise
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus: directed corners, a stacking run, then random traffic
   // ---------------------------------------------------------------------------------
   initial begin
      queue_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0, '0, '0, '0));
      queue_item(make_item(KIND_QUERY, 1, 0, 0, 0, 0, '0, '0, '0));           // nothing written
      queue_item(make_item(KIND_VERTEX, 0, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX));  // index zero
      queue_item(make_item(KIND_VERTEX, 1025, 0, 0, 0, 0, C_MIN, C_MIN, C_MIN));
      queue_item(make_item(KIND_VERTEX, 2047, 2047, 2047, 2047, 7, C_MAX, C_MIN, '1));
      // square in the xy plane at full coordinate span
      queue_item(make_item(KIND_VERTEX, 1, 0, 0, 0, 0, C_MAX, C_MIN, '0));
      queue_item(make_item(KIND_VERTEX, 2, 0, 0, 0, 0, C_MIN, C_MIN, '0));
      queue_item(make_item(KIND_VERTEX, 3, 0, 0, 0, 0, C_MIN, C_MAX, '0));
      queue_item(make_item(KIND_VERTEX, 4, 0, 0, 0, 0, C_MAX, C_MAX, '0));
      queue_item(make_item(KIND_QUERY, 1, 0, 0, 0, 0, '0, '0, '0));           // zero length
      queue_item(make_item(KIND_FACE, 1, 2, 3, 0, CORNERS_TRI, '0, '0, '0));
      queue_item(make_item(KIND_FACE, 1, 2, 3, 4, CORNERS_QUAD, '0, '0, '0));
      queue_item(make_item(KIND_FACE, 1, 2, 3, 4, 0, '0, '0, '0));             // bad corner count
      queue_item(make_item(KIND_FACE, 1, 2, 3, 4, 7, '0, '0, '0));
      queue_item(make_item(KIND_FACE, 1, 2, 5, 0, CORNERS_TRI, '0, '0, '0));   // above count
      queue_item(make_item(KIND_FACE, 0, 2, 3, 0, CORNERS_TRI, '0, '0, '0));   // index zero
      queue_item(make_item(KIND_FACE, 1, 2, 3, 9, CORNERS_QUAD, '0, '0, '0));  // bad fourth corner
      queue_item(make_item(KIND_VERTEX, 1024, 0, 0, 0, 0, C_MIN, C_MAX, C_MAX));
      queue_item(make_item(KIND_QUERY, 1024, 0, 0, 0, 0, '0, '0, '0));
      queue_item(make_item(KIND_FACE, 1, 2, 1024, 0, CORNERS_TRI, '0, '0, '0));
      for (int i = 1; i <= 4; i++)
         queue_item(make_item(KIND_QUERY, i, 0, 0, 0, 0, '0, '0, '0));
      queue_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0, '0, '0, '0));
      queue_item(make_item(KIND_QUERY, 1, 0, 0, 0, 0, '0, '0, '0));           // count cleared

      // Rewrite the square and stack quads of both windings on it.
      queue_item(make_item(KIND_VERTEX, 1, 0, 0, 0, 0, C_MAX, C_MIN, '0));
      queue_item(make_item(KIND_VERTEX, 2, 0, 0, 0, 0, C_MIN, C_MIN, '0));
      queue_item(make_item(KIND_VERTEX, 3, 0, 0, 0, 0, C_MIN, C_MAX, '0));
      queue_item(make_item(KIND_VERTEX, 4, 0, 0, 0, 0, C_MAX, C_MAX, '0));
      for (int i = 0; i < HAMMER_QUADS; i++) begin
         if (i % 2 == 0) queue_item(make_item(KIND_FACE, 1, 2, 3, 4, CORNERS_QUAD, '0, '0, '0));
         else queue_item(make_item(KIND_FACE, 4, 3, 2, 1, CORNERS_QUAD, '0, '0, '0));
         if (i % 50 == 49) queue_item(make_item(KIND_QUERY, 1, 0, 0, 0, 0, '0, '0, '0));
      end
      for (int i = 1; i <= 4; i++)
         queue_item(make_item(KIND_QUERY, i, 0, 0, 0, 0, '0, '0, '0));

      for (int i = 0; i < RANDOM_ITEMS; i++) queue_item(random_item());
   end

   // ---------------------------------------------------------------------------------
   // Driver: bursts with random gaps; a stalled beat holds until taken
   // ---------------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled beat
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (pending.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= pending[0];
         if (burst_left == 0) burst_left = $urandom_range(16, 1);
         burst_left = burst_left - 1;
         if (burst_left == 0 && $urandom_range(1)) gap_left = $urandom_range(8, 1);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: a stall mode redrawn at random, from never to mostly stalled.
   int stall_phase = 0;
   int stall_mode = 0;

   always @(negedge clock) begin
      stall_phase = stall_phase + 1;
      if (stall_phase % 256 == 0) stall_mode = $urandom_range(3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(3) == 0);
         2:       rsp_stall <= ($urandom_range(3) != 0);
         default: rsp_stall <= ((stall_phase / 16) % 2 == 1);
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Monitor: predict on each input beat, compare on each result beat
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            normals_due = {normals_due, predict_normal(req_data)};
            void'(pending.pop_front());
            beats_in = beats_in + 1;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (normals_due.size() == 0) begin
               $error("result beat with no expectation pending: %h", rsp_data);
               errors = errors + 1;
            end else begin
               want = normals_due.pop_front();
               if (rsp_data.normal_x !== want.normal_x) begin
                  $error("normal_x expected %0d actual %0d", want.normal_x, rsp_data.normal_x);
                  errors = errors + 1;
               end
               if (rsp_data.normal_y !== want.normal_y) begin
                  $error("normal_y expected %0d actual %0d", want.normal_y, rsp_data.normal_y);
                  errors = errors + 1;
               end
               if (rsp_data.normal_z !== want.normal_z) begin
                  $error("normal_z expected %0d actual %0d", want.normal_z, rsp_data.normal_z);
                  errors = errors + 1;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  errors = errors + 1;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, normals_due.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Reset, drain and verdict
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending.size() == 0 && normals_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (normals_due.size() != 0) begin
         $error("%0d expected results never arrived", normals_due.size());
         errors = errors + 1;
      end
      $display("Ran %0d beats: %0d normals returned, %0d zero-length, %0d rejected,",
               beats_in, ok_queries, zero_queries, rejects);
      $display("%0d clamped components read back, with random gaps and output stalls.",
               saturated_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### vertex_normal_accumulator_top.f
hdl/vna_pkg.sv
hdl/vna_ram.sv
hdl/vna_front.sv
hdl/vna_fifo.sv
hdl/vna_back.sv
hdl/vertex_normal_accumulator_top.sv
tb/tb_vertex_normal_accumulator_top.sv
